/* hw/rtl/pwtd_pkg.sv */
// Package for the PID controller with tracking differentiator.
// Holds field widths, register indexes, the register struct and sequencer states.
// No dependencies.
package pwtd_pkg;

	localparam int DATA_W     = 32;
	localparam int LIM_W      = 31;
	localparam int SUM_W      = 48;
	localparam int SUM_LO_W   = 16;
	localparam int MUL_W      = 33;
	localparam int CFG_IDX_W  = 4;
	// differentiator step h = 2^-STEP_SHIFT
	localparam int STEP_SHIFT = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_OUTPUT_LIMIT,
		REG_INTEGRAL_GATE,
		REG_INTEGRAL_TERM_LIMIT,
		REG_DIFF_RATE,
		REG_DIFF_SLOPE_LIMIT
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic [LIM_W-1:0]         output_limit;
		logic [LIM_W-1:0]         integral_gate;
		logic [LIM_W-1:0]         integral_term_limit;
		logic [LIM_W-1:0]         diff_rate;
		logic [LIM_W-1:0]         diff_slope_limit;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DIFF,
		ST_RR,
		ST_PTERM,
		ST_T2,
		ST_RATE,
		ST_SLOPE,
		ST_ITERM,
		ST_DTERM,
		ST_DONE
	} seq_state_t;

endpackage

/* hw/rtl/pwtd_channels.sv */
// Valid/ready channel interfaces: sample in, result out, register write.
// Depends on pwtd_pkg for field widths.
interface pwtd_sample_if;
	import pwtd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] setpoint;
	logic signed [DATA_W-1:0] feedback;
	modport source (output valid, output setpoint, output feedback, input ready);
	modport sink (input valid, input setpoint, input feedback, output ready);
endinterface

interface pwtd_result_if;
	import pwtd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic signed [DATA_W-1:0] error_rate;
	logic                     drive_clamped;
	modport source (output valid, output drive, output error_rate, output drive_clamped,
		input ready);
	modport sink (input valid, input drive, input error_rate, input drive_clamped,
		output ready);
endinterface

interface pwtd_cfg_if;
	import pwtd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/pwtd_cfg_regs.sv */
// Configuration register file, written through the register channel.
// Depends on pwtd_pkg and pwtd_cfg_if.
module pwtd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	pwtd_cfg_if.sink      cfg,
	output pwtd_pkg::cfg_t regs
);
	import pwtd_pkg::*;

	cfg_t regs_q;

	// always able to take a write
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GAIN_P:              regs_q.gain_p <= $signed(cfg.data);
				REG_GAIN_I:              regs_q.gain_i <= $signed(cfg.data);
				REG_GAIN_D:              regs_q.gain_d <= $signed(cfg.data);
				REG_OUTPUT_LIMIT:        regs_q.output_limit <= cfg.data[LIM_W-1:0];
				REG_INTEGRAL_GATE:       regs_q.integral_gate <= cfg.data[LIM_W-1:0];
				REG_INTEGRAL_TERM_LIMIT: regs_q.integral_term_limit <= cfg.data[LIM_W-1:0];
				REG_DIFF_RATE:           regs_q.diff_rate <= cfg.data[LIM_W-1:0];
				REG_DIFF_SLOPE_LIMIT:    regs_q.diff_slope_limit <= cfg.data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/pwtd_mul.sv */
// Shared signed multiplier, 33 x 33 bits, product registered.
// Depends on pwtd_pkg.
module pwtd_mul (
	input  logic                             clk,
	input  logic signed [pwtd_pkg::MUL_W-1:0] a,
	input  logic signed [pwtd_pkg::MUL_W-1:0] b,
	output logic signed [2*pwtd_pkg::MUL_W-1:0] prod_q
);
	import pwtd_pkg::*;

	// one product per cycle
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

/* hw/rtl/pwtd_core.sv */
// Sequencer and datapath: error, tracking differentiator, PID terms, clamps.
// Depends on pwtd_pkg, pwtd_channels and pwtd_mul.
module pwtd_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pwtd_pkg::cfg_t regs,
	pwtd_sample_if.sink    sample,
	pwtd_result_if.source  result
);
	import pwtd_pkg::*;

	localparam int PW   = 2 * MUL_W;           // product width
	localparam int SHW  = PW - FRAC_BITS;       // product after fraction shift
	localparam int AW   = SHW + 2;              // rate accumulator
	localparam int RW   = AW + 1;               // rate update sum
	localparam int IT_W = PW + SUM_LO_W;        // integral product
	localparam int ISW  = IT_W - FRAC_BITS;     // integral product after shift
	localparam int DW   = SHW + 2;              // P + I + D

	seq_state_t state_q, state_d;
	logic       sample_ready;
	logic       out_load;
	logic       in_fire;

	// controller state
	logic signed [DATA_W-1:0] te_q;
	logic signed [DATA_W-1:0] tr_q;
	logic signed [SUM_W-1:0]  sum_q;

	// work registers
	logic signed [DATA_W-1:0] sp_q, fb_q, e_q, it_q;
	logic signed [DATA_W:0]   diff_q;
	logic [LIM_W-1:0]         rr_q;
	logic signed [SHW-1:0]    p_q;
	logic signed [AW-1:0]     acc_q;
	logic signed [IT_W-1:0]   itacc_q;
	logic signed [DW-1:0]     drv_q;

	// result register
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q, rate_q;
	logic                     clamped_q;

	// multiplier
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PW-1:0]    prod_q;
	logic signed [SHW-1:0]   prod_sh;

	// operand views
	logic signed [MUL_W-1:0] r_x, tr_x, e_x, rr_x, gp_x, gi_x, gd_x, hi_x, lo_x;

	// combinational datapath values
	logic signed [DATA_W:0]   err_raw, te_raw, mag;
	logic signed [DATA_W-1:0] err_sat, te_sat, tr_step, tr_sat, tr_lim, slope_pos;
	logic signed [SUM_W:0]    sum_raw;
	logic signed [SUM_W-1:0]  sum_sat;
	logic [LIM_W-1:0]         rr_sat;
	logic signed [AW-1:0]     acc_sh;
	logic signed [RW-1:0]     rate_raw;
	logic signed [ISW-1:0]    it_sh, it_pos;
	logic signed [DATA_W-1:0] it_lim;
	logic signed [DW-1:0]     drv_pos;
	logic signed [DATA_W-1:0] drive_d;
	logic                     clamped_d;

	assign in_fire = sample.valid && sample_ready;
	assign sample.ready = sample_ready;

	assign result.valid         = out_valid_q;
	assign result.drive         = drive_q;
	assign result.error_rate    = rate_q;
	assign result.drive_clamped = clamped_q;

	assign r_x  = $signed({2'b00, regs.diff_rate});
	assign tr_x = $signed({tr_q[DATA_W-1], tr_q});
	assign e_x  = $signed({e_q[DATA_W-1], e_q});
	assign rr_x = $signed({2'b00, rr_q});
	assign gp_x = $signed({regs.gain_p[DATA_W-1], regs.gain_p});
	assign gi_x = $signed({regs.gain_i[DATA_W-1], regs.gain_i});
	assign gd_x = $signed({regs.gain_d[DATA_W-1], regs.gain_d});
	assign hi_x = $signed({sum_q[SUM_W-1], sum_q[SUM_W-1:SUM_LO_W]});
	assign lo_x = $signed({{(MUL_W-SUM_LO_W){1'b0}}, sum_q[SUM_LO_W-1:0]});

	pwtd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// floor(product / 2^FRAC_BITS)
	assign prod_sh = $signed(prod_q[PW-1:FRAC_BITS]);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, handshake and multiplier operand select
	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		out_load     = 1'b0;
		mul_a        = r_x;
		mul_b        = tr_x;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample.valid) state_d = ST_ERR;
			end
			ST_ERR: begin
				// r * old rate
				mul_a   = r_x;
				mul_b   = tr_x;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				mul_a   = r_x;
				mul_b   = r_x;
				state_d = ST_RR;
			end
			ST_RR: begin
				mul_a   = gp_x;
				mul_b   = e_x;
				state_d = ST_PTERM;
			end
			ST_PTERM: begin
				mul_a   = rr_x;
				mul_b   = diff_q;
				state_d = ST_T2;
			end
			ST_T2: begin
				mul_a   = hi_x;
				mul_b   = gi_x;
				state_d = ST_RATE;
			end
			ST_RATE: begin
				mul_a   = lo_x;
				mul_b   = gi_x;
				state_d = ST_SLOPE;
			end
			ST_SLOPE: begin
				state_d = ST_ITERM;
			end
			ST_ITERM: begin
				// gain_d * updated rate
				mul_a   = gd_x;
				mul_b   = tr_x;
				state_d = ST_DTERM;
			end
			ST_DTERM: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// saturating adds, clamps and arithmetic shifts
	always_comb begin
		// error = sat32(setpoint - feedback)
		err_raw = $signed({sp_q[DATA_W-1], sp_q}) - $signed({fb_q[DATA_W-1], fb_q});
		if (err_raw[DATA_W] != err_raw[DATA_W-1])
			err_sat = err_raw[DATA_W] ? $signed({1'b1, {(DATA_W-1){1'b0}}})
				: $signed({1'b0, {(DATA_W-1){1'b1}}});
		else
			err_sat = err_raw[DATA_W-1:0];

		// tracked error moves by rate * h
		tr_step = tr_q >>> STEP_SHIFT;
		te_raw  = $signed({te_q[DATA_W-1], te_q}) + $signed({tr_step[DATA_W-1], tr_step});
		if (te_raw[DATA_W] != te_raw[DATA_W-1])
			te_sat = te_raw[DATA_W] ? $signed({1'b1, {(DATA_W-1){1'b0}}})
				: $signed({1'b0, {(DATA_W-1){1'b1}}});
		else
			te_sat = te_raw[DATA_W-1:0];

		// integral gate and 48-bit saturating sum
		mag     = e_q[DATA_W-1] ? -$signed({e_q[DATA_W-1], e_q}) : $signed({1'b0, e_q});
		sum_raw = $signed({sum_q[SUM_W-1], sum_q})
			+ $signed({{(SUM_W-DATA_W+1){e_q[DATA_W-1]}}, e_q});
		if (sum_raw[SUM_W] != sum_raw[SUM_W-1])
			sum_sat = sum_raw[SUM_W] ? $signed({1'b1, {(SUM_W-1){1'b0}}})
				: $signed({1'b0, {(SUM_W-1){1'b1}}});
		else
			sum_sat = sum_raw[SUM_W-1:0];

		// r*r, product is never negative
		if (|prod_q[PW-1:FRAC_BITS+LIM_W])
			rr_sat = {LIM_W{1'b1}};
		else
			rr_sat = prod_q[FRAC_BITS+LIM_W-1:FRAC_BITS];

		// rate moves by acc * h
		acc_sh   = acc_q >>> STEP_SHIFT;
		rate_raw = $signed({acc_sh[AW-1], acc_sh})
			+ $signed({{(RW-DATA_W){tr_q[DATA_W-1]}}, tr_q});
		if ((&rate_raw[RW-1:DATA_W-1]) || !(|rate_raw[RW-1:DATA_W-1]))
			tr_sat = rate_raw[DATA_W-1:0];
		else
			tr_sat = rate_raw[RW-1] ? $signed({1'b1, {(DATA_W-1){1'b0}}})
				: $signed({1'b0, {(DATA_W-1){1'b1}}});

		// optional slope clamp
		slope_pos = $signed({1'b0, regs.diff_slope_limit});
		if (regs.diff_slope_limit != '0 && tr_q > slope_pos)
			tr_lim = slope_pos;
		else if (regs.diff_slope_limit != '0 && tr_q < -slope_pos)
			tr_lim = -slope_pos;
		else
			tr_lim = tr_q;

		// integral term clamp
		it_sh  = $signed(itacc_q[IT_W-1:FRAC_BITS]);
		it_pos = $signed({{(ISW-LIM_W){1'b0}}, regs.integral_term_limit});
		if (it_sh > it_pos)
			it_lim = $signed({1'b0, regs.integral_term_limit});
		else if (it_sh < -it_pos)
			it_lim = -$signed({1'b0, regs.integral_term_limit});
		else
			it_lim = it_sh[DATA_W-1:0];

		// drive clamp
		drv_pos = $signed({{(DW-LIM_W){1'b0}}, regs.output_limit});
		if (drv_q > drv_pos) begin
			drive_d   = $signed({1'b0, regs.output_limit});
			clamped_d = 1'b1;
		end else if (drv_q < -drv_pos) begin
			drive_d   = -$signed({1'b0, regs.output_limit});
			clamped_d = 1'b1;
		end else begin
			drive_d   = drv_q[DATA_W-1:0];
			clamped_d = 1'b0;
		end
	end

	// controller state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			te_q        <= '0;
			tr_q        <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_ERR) te_q <= te_sat;
			if (state_q == ST_DIFF && mag < $signed({2'b00, regs.integral_gate}))
				sum_q <= sum_sat;
			if (state_q == ST_RATE) tr_q <= tr_sat;
			if (state_q == ST_SLOPE) tr_q <= tr_lim;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// work and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sp_q <= sample.setpoint;
			fb_q <= sample.feedback;
		end
		case (state_q)
			ST_ERR:   e_q <= err_sat;
			ST_DIFF: begin
				diff_q <= $signed({te_q[DATA_W-1], te_q}) - $signed({e_q[DATA_W-1], e_q});
				// -2 * t1
				acc_q  <= -($signed({{2{prod_sh[SHW-1]}}, prod_sh}) <<< 1);
			end
			ST_RR:    rr_q <= rr_sat;
			ST_PTERM: p_q <= prod_sh;
			ST_T2:    acc_q <= acc_q - $signed({{2{prod_sh[SHW-1]}}, prod_sh});
			ST_RATE:  itacc_q <= $signed({prod_q, {SUM_LO_W{1'b0}}});
			ST_SLOPE: itacc_q <= itacc_q + $signed({{SUM_LO_W{prod_q[PW-1]}}, prod_q});
			ST_ITERM: it_q <= it_lim;
			ST_DTERM: drv_q <= $signed({{2{p_q[SHW-1]}}, p_q})
				+ $signed({{(DW-DATA_W){it_q[DATA_W-1]}}, it_q})
				+ $signed({{2{prod_sh[SHW-1]}}, prod_sh});
			default: ;
		endcase
		if (out_load) begin
			drive_q   <= drive_d;
			rate_q    <= tr_q;
			clamped_q <= clamped_d;
		end
	end

	// no new sample while one is in work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !sample_ready)
		else $error("sample taken while previous one in work");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || result.ready))
		else $error("result register overwritten");

	// rate lies within slope limit after clamp
	a_slope_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SLOPE && regs.diff_slope_limit != '0) |=>
		(tr_q <= $signed({1'b0, $past(regs.diff_slope_limit)})
		&& tr_q >= -$signed({1'b0, $past(regs.diff_slope_limit)})))
		else $error("rate outside slope limit");

	// integral term inside its limit when the sum is formed
	a_iterm_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DTERM) |->
		(it_q <= $signed({1'b0, regs.integral_term_limit})
		&& it_q >= -$signed({1'b0, regs.integral_term_limit})))
		else $error("integral term outside limit");

endmodule

/* hw/rtl/pid_with_tracking_differentiator_top.sv */
// Top level of the PID controller with tracking differentiator on the error.
// Depends on pwtd_pkg, pwtd_channels, pwtd_cfg_regs and pwtd_core.
//
//   channel  | role   | word
//   ---------+--------+---------------------------------------------
//   sample   | sink   | setpoint, feedback (signed Q16.16)
//   result   | source | drive, error_rate (signed), drive_clamped
//   cfg      | sink   | index, data (register write, always ready)
//
// One word passes through the accept cycle in idle and ten sequencer steps
// before the next accept. Seven of those steps start a product on the single
// shared 33x33 multiplier, whose registered output the next step uses.
// A result waiting in the output register holds the sequencer in its last step
// until the result is taken; sample.ready is high only while idle.
// Reset clears gains, limits, differentiator state and the integral sum.
module pid_with_tracking_differentiator_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	pwtd_cfg_if.sink      cfg,
	pwtd_sample_if.sink   sample,
	pwtd_result_if.source result
);
	import pwtd_pkg::*;

	cfg_t regs;

	pwtd_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pwtd_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.sample (sample),
		.result (result)
	);

endmodule
